// File: src/tlp_pkg.sv
// ----------------------------------------------------------------------------
// tlp_pkg
// Shared constants, types and the sigmoid breakpoint table for the
// two-layer perceptron unit.
// ----------------------------------------------------------------------------
package tlp_pkg;

  localparam int MAX_INPUTS  = 1024;
  localparam int MAX_HIDDEN  = 128;
  localparam int NUM_OUTPUTS = 3;

  localparam int SRC_W  = 10;
  localparam int DST_W  = 7;
  localparam int VAL_W  = 16;
  localparam int NI_W   = 11;
  localparam int NH_W   = 8;
  localparam int CFG_W  = 11;
  localparam int HACC_W = 42;
  localparam int OACC_W = 40;

  localparam logic CFG_INPUTS = 1'b0;
  localparam logic CFG_HIDDEN = 1'b1;

  typedef enum logic [1:0] {
    REQ_HIDDEN_W = 2'd0,
    REQ_OUTPUT_W = 2'd1,
    REQ_FEATURE  = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  typedef struct packed {
    logic             outp;
    logic [DST_W-1:0] idx;
  } sig_tag_t;

  function automatic logic [15:0] sig_tab(input logic [4:0] n);
    logic [15:0] r;
    unique case (n)
      5'd0:  r = 16'd32768;
      5'd1:  r = 16'd40793;
      5'd2:  r = 16'd47910;
      5'd3:  r = 16'd53580;
      5'd4:  r = 16'd57724;
      5'd5:  r = 16'd60565;
      5'd6:  r = 16'd62428;
      5'd7:  r = 16'd63615;
      5'd8:  r = 16'd64357;
      5'd9:  r = 16'd64816;
      5'd10: r = 16'd65097;
      5'd11: r = 16'd65269;
      5'd12: r = 16'd65374;
      5'd13: r = 16'd65437;
      5'd14: r = 16'd65476;
      5'd15: r = 16'd65500;
      default: r = 16'd65514;
    endcase
    return r;
  endfunction

endpackage

// File: src/tlp_mac_cell.sv
// ----------------------------------------------------------------------------
// tlp_mac_cell
// One accumulator cell of the hidden-sum ring; takes its neighbor's value
// on every shift.
// ----------------------------------------------------------------------------
module tlp_mac_cell (
  input  logic                               clk,
  input  logic                               clear,
  input  logic                               shift,
  input  logic signed [tlp_pkg::HACC_W-1:0]  din,
  output logic signed [tlp_pkg::HACC_W-1:0]  acc
);

  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= '0;
    end else if (shift) begin
      acc <= din;
    end
  end

endmodule

// File: src/tlp_sigmoid.sv
// ----------------------------------------------------------------------------
// tlp_sigmoid
// Two-stage piecewise-linear sigmoid, signed Q4.12 in, unsigned Q0.16 out.
// ----------------------------------------------------------------------------
module tlp_sigmoid (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_v,
  input  logic signed [15:0]      z,
  input  tlp_pkg::sig_tag_t       in_tag,
  output logic                    out_v,
  output logic [15:0]             y,
  output tlp_pkg::sig_tag_t       out_tag,
  output logic                    busy
);

  logic              s1_v;
  logic [15:0]       s1_base;
  logic [12:0]       s1_diff;
  logic [10:0]       s1_frac;
  logic              s1_neg;
  tlp_pkg::sig_tag_t s1_tag;

  logic [16:0] m;
  logic [4:0]  seg;
  logic [15:0] t_lo;
  logic [15:0] t_hi;
  logic [23:0] prod;
  logic [15:0] g;

  assign m    = z[15] ? (17'd0 - {z[15], z}) : {1'b0, z};
  assign seg  = m[15:11] | {m[16], 4'b0};
  assign t_lo = tlp_pkg::sig_tab(seg);
  assign t_hi = tlp_pkg::sig_tab(seg + 5'd1);
  assign prod = {11'd0, s1_diff} * {13'd0, s1_frac};
  assign g    = s1_base + 16'(prod[23:11]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      s1_v  <= in_v;
      out_v <= s1_v;
    end
    s1_base <= t_lo;
    s1_diff <= m[16] ? 13'd0 : 13'(t_hi - t_lo);
    s1_frac <= m[16] ? 11'd0 : m[10:0];
    s1_neg  <= z[15];
    s1_tag  <= in_tag;
    y       <= s1_neg ? 16'(17'h10000 - {1'b0, g}) : g;
    out_tag <= s1_tag;
  end

  assign busy = s1_v | out_v;

endmodule

// File: src/two_layer_perceptron_sigmoid_unit.sv
// ----------------------------------------------------------------------------
// two_layer_perceptron_sigmoid_unit
// One-hidden-layer perceptron with sigmoid activations. Requests load weights
// or feature elements; a feature marked last runs the network and yields
// three output activations with the arg-max class.
//
//   channel | signals                                          | dir
//   --------+--------------------------------------------------+-----
//   request | in_valid/in_ready, req_type, src_index,          | in
//           | dst_neuron, value, last                          |
//   result  | out_valid/out_ready, out_index, activation,      | out
//           | best_class, last_result                          |
//   config  | cfg_we, cfg_index, cfg_data                      | in
//
// The hidden phase is set by the single multiplier feeding the 128-cell
// accumulator ring, which steps through all 128 cells for each of the NI
// inputs (NI the clamped input count).
// Reset is synchronous and clears control only; memories hold no reset.
// Requests wait while a run is active; results stall without loss.
// ----------------------------------------------------------------------------
module two_layer_perceptron_sigmoid_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      req_type,
  input  logic [tlp_pkg::SRC_W-1:0]       src_index,
  input  logic [tlp_pkg::DST_W-1:0]       dst_neuron,
  input  logic signed [tlp_pkg::VAL_W-1:0] value,
  input  logic                            last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_index,
  output logic [15:0]                     activation,
  output logic [1:0]                      best_class,
  output logic                            last_result,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [tlp_pkg::CFG_W-1:0]       cfg_data
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_HID   = 9'b000000010,
    S_HWAIT = 9'b000000100,
    S_HACT  = 9'b000001000,
    S_AWAIT = 9'b000010000,
    S_OUT   = 9'b000100000,
    S_OWAIT = 9'b001000000,
    S_OSIG  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  localparam int NCELL = tlp_pkg::MAX_HIDDEN;

  state_t state;

  logic [tlp_pkg::NI_W-1:0] inputs_in_use;
  logic [tlp_pkg::NH_W-1:0] hidden_in_use;
  logic [tlp_pkg::NI_W-1:0] ni;
  logic [tlp_pkg::NH_W-1:0] nh;

  logic [15:0] hw_mem [0:tlp_pkg::MAX_INPUTS*tlp_pkg::MAX_HIDDEN-1];
  logic [15:0] ow_mem [0:tlp_pkg::MAX_HIDDEN*tlp_pkg::NUM_OUTPUTS-1];
  logic [15:0] ft_mem [0:tlp_pkg::MAX_INPUTS-1];
  logic [15:0] ac_mem [0:tlp_pkg::MAX_HIDDEN-1];

  logic [9:0] j;
  logic [6:0] hi;
  logic [6:0] h;
  logic [1:0] k;

  logic        v1;
  logic        v2;
  logic        ov1;
  logic        ov2;
  logic [15:0] hw_rd;
  logic [15:0] ft_rd;
  logic [15:0] ow_rd;
  logic [15:0] ac_rd;
  logic signed [31:0] hprod;
  logic signed [32:0] oprod;
  logic signed [tlp_pkg::OACC_W-1:0] oacc;

  logic signed [tlp_pkg::HACC_W-1:0] acc [0:NCELL-1];
  logic signed [tlp_pkg::HACC_W-1:0] head_sum;
  logic ring_clear;
  logic ring_shift;

  logic              sig_in_v;
  logic signed [15:0] sig_z;
  tlp_pkg::sig_tag_t sig_in_tag;
  logic              sig_out_v;
  logic [15:0]       sig_y;
  tlp_pkg::sig_tag_t sig_out_tag;
  logic              sig_busy;

  logic [29:0] hz;
  logic [23:0] oz;
  logic [15:0] hz_sat;
  logic [15:0] oz_sat;

  logic [15:0] res [0:tlp_pkg::NUM_OUTPUTS-1];
  logic [15:0] outr [0:tlp_pkg::NUM_OUTPUTS-1];
  logic [1:0]  best;
  logic [1:0]  best_next;
  logic [1:0]  ocnt;
  logic        accept;
  logic        h_last;
  logic        hi_end;

  assign ni = (inputs_in_use > tlp_pkg::NI_W'(tlp_pkg::MAX_INPUTS)) ?
              tlp_pkg::NI_W'(tlp_pkg::MAX_INPUTS) : inputs_in_use;
  assign nh = (hidden_in_use > tlp_pkg::NH_W'(tlp_pkg::MAX_HIDDEN)) ?
              tlp_pkg::NH_W'(tlp_pkg::MAX_HIDDEN) : hidden_in_use;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign h_last   = ({1'b0, h} == nh - tlp_pkg::NH_W'(1));
  assign hi_end   = (hi == 7'(NCELL - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      inputs_in_use <= tlp_pkg::NI_W'(636);
      hidden_in_use <= tlp_pkg::NH_W'(120);
    end else if (cfg_we) begin
      unique case (cfg_index)
        tlp_pkg::CFG_INPUTS: inputs_in_use <= cfg_data;
        tlp_pkg::CFG_HIDDEN: hidden_in_use <= cfg_data[tlp_pkg::NH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req_type == tlp_pkg::REQ_HIDDEN_W) begin
      hw_mem[{src_index, dst_neuron}] <= value;
    end
    hw_rd <= hw_mem[{j, hi}];
  end

  always_ff @(posedge clk) begin
    if (accept && req_type == tlp_pkg::REQ_FEATURE) begin
      ft_mem[src_index] <= value;
    end
    ft_rd <= ft_mem[j];
  end

  always_ff @(posedge clk) begin
    if (accept && req_type == tlp_pkg::REQ_OUTPUT_W && src_index[9:7] == 3'd0 &&
        dst_neuron < 7'(tlp_pkg::NUM_OUTPUTS)) begin
      ow_mem[9'(src_index[6:0]) * 9'd3 + 9'(dst_neuron[1:0])] <= value;
    end
    ow_rd <= ow_mem[9'(h) * 9'd3 + 9'(k)];
  end

  always_ff @(posedge clk) begin
    if (sig_out_v && !sig_out_tag.outp) begin
      ac_mem[sig_out_tag.idx] <= sig_y;
    end
    ac_rd <= ac_mem[h];
  end

  assign head_sum   = acc[0] + (v2 ? tlp_pkg::HACC_W'(hprod) : '0);
  assign ring_clear = accept;
  assign ring_shift = v2 | (state == S_HACT);

  for (genvar c = 0; c < NCELL; c++) begin : g_ring
    tlp_mac_cell u_cell (
      .clk   (clk),
      .clear (ring_clear),
      .shift (ring_shift),
      .din   ((c == NCELL - 1) ? head_sum : acc[(c + 1) % NCELL]),
      .acc   (acc[c])
    );
  end

  assign hz = 30'(acc[0] >>> 12);
  assign oz = 24'(oacc >>> 16);

  always_comb begin
    if (!hz[29] && |hz[28:15]) begin
      hz_sat = 16'h7fff;
    end else if (hz[29] && !(&hz[28:15])) begin
      hz_sat = 16'h8000;
    end else begin
      hz_sat = hz[15:0];
    end
    if (!oz[23] && |oz[22:15]) begin
      oz_sat = 16'h7fff;
    end else if (oz[23] && !(&oz[22:15])) begin
      oz_sat = 16'h8000;
    end else begin
      oz_sat = oz[15:0];
    end
  end

  assign sig_in_v        = (state == S_HACT) | (state == S_OWAIT && !ov1 && !ov2);
  assign sig_z           = (state == S_HACT) ? hz_sat : oz_sat;
  assign sig_in_tag.outp = (state != S_HACT);
  assign sig_in_tag.idx  = (state == S_HACT) ? h : 7'(k);

  tlp_sigmoid u_sig (
    .clk     (clk),
    .rst     (rst),
    .in_v    (sig_in_v),
    .z       (sig_z),
    .in_tag  (sig_in_tag),
    .out_v   (sig_out_v),
    .y       (sig_y),
    .out_tag (sig_out_tag),
    .busy    (sig_busy)
  );

  always_ff @(posedge clk) begin
    hprod <= $signed(hw_rd) * $signed(ft_rd);
    oprod <= $signed(ow_rd) * $signed({1'b0, ac_rd});
    if (sig_out_v && sig_out_tag.outp) begin
      res[sig_out_tag.idx[1:0]] <= sig_y;
    end
  end

  always_comb begin
    best_next = 2'd0;
    if (res[1] > res[0]) begin
      best_next = 2'd1;
    end
    if (res[2] > res[best_next]) begin
      best_next = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      v1        <= 1'b0;
      v2        <= 1'b0;
      ov1       <= 1'b0;
      ov2       <= 1'b0;
      out_valid <= 1'b0;
      ocnt      <= 2'd0;
      j         <= '0;
      hi        <= '0;
      h         <= '0;
      k         <= '0;
    end else begin
      v1  <= (state == S_HID);
      v2  <= v1;
      ov1 <= (state == S_OUT);
      ov2 <= ov1;
      if (ov2) begin
        oacc <= oacc + tlp_pkg::OACC_W'(oprod);
      end
      if (out_valid && out_ready) begin
        if (ocnt == 2'(tlp_pkg::NUM_OUTPUTS - 1)) begin
          out_valid <= 1'b0;
          ocnt      <= 2'd0;
        end else begin
          ocnt <= ocnt + 2'd1;
        end
      end
      unique case (state)
        S_IDLE: begin
          j  <= '0;
          hi <= '0;
          h  <= '0;
          k  <= '0;
          if (accept && req_type == tlp_pkg::REQ_FEATURE && last) begin
            state <= (ni == '0) ? S_HWAIT : S_HID;
          end
        end
        S_HID: begin
          hi <= hi + 7'd1;
          if (hi_end) begin
            j <= j + 10'd1;
            if ({1'b0, j} == ni - tlp_pkg::NI_W'(1)) begin
              state <= S_HWAIT;
            end
          end
        end
        S_HWAIT: begin
          if (!v1 && !v2) begin
            h     <= '0;
            state <= (nh == '0) ? S_AWAIT : S_HACT;
          end
        end
        S_HACT: begin
          h <= h + 7'd1;
          if (h_last) begin
            state <= S_AWAIT;
          end
        end
        S_AWAIT: begin
          h    <= '0;
          oacc <= '0;
          if (!sig_busy) begin
            state <= (nh == '0) ? S_OWAIT : S_OUT;
          end
        end
        S_OUT: begin
          h <= h + 7'd1;
          if (h_last) begin
            state <= S_OWAIT;
          end
        end
        S_OWAIT: begin
          if (!ov1 && !ov2) begin
            state <= S_OSIG;
          end
        end
        S_OSIG: begin
          if (sig_out_v) begin
            h    <= '0;
            oacc <= '0;
            if (k == 2'(tlp_pkg::NUM_OUTPUTS - 1)) begin
              state <= S_DONE;
            end else begin
              k     <= k + 2'd1;
              state <= (nh == '0) ? S_OWAIT : S_OUT;
            end
          end
        end
        S_DONE: begin
          if (!out_valid) begin
            outr[0]   <= res[0];
            outr[1]   <= res[1];
            outr[2]   <= res[2];
            best      <= best_next;
            out_valid <= 1'b1;
            ocnt      <= 2'd0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_index   = ocnt;
  assign activation  = outr[ocnt];
  assign best_class  = best;
  assign last_result = (ocnt == 2'(tlp_pkg::NUM_OUTPUTS - 1));

endmodule

// File: src/tlp_checker.sv
// ----------------------------------------------------------------------------
// tlp_port_checker
// Port-level checks on the result channel of the perceptron unit.
// ----------------------------------------------------------------------------
module tlp_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_index,
  input logic [15:0] activation,
  input logic [1:0]  best_class,
  input logic        last_result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(activation) && $stable(out_index))
    else $error("stalled result changed");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_result == (out_index == 2'd2)))
    else $error("last_result on wrong index");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_result |=> out_valid && out_index == $past(out_index) + 2'd1)
    else $error("result burst broken");

  a_best: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_result |=> best_class == $past(best_class))
    else $error("best_class changed within run");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind two_layer_perceptron_sigmoid_unit tlp_port_checker u_tlp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_index   (out_index),
  .activation  (activation),
  .best_class  (best_class),
  .last_result (last_result)
);

// File: verif/tlp_checker.sv
// ----------------------------------------------------------------------------
// tlp_checker
// Watches the request, result and config ports of the perceptron unit. It
// keeps its own copy of the weight and feature memories and of both counts,
// works out the three output activations and the arg-max class of each run,
// and compares every accepted result with the oldest expected one.
// ----------------------------------------------------------------------------
module tlp_checker
  import tlp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [1:0]       req_type,
  input  logic [SRC_W-1:0] src_index,
  input  logic [DST_W-1:0] dst_neuron,
  input  logic [VAL_W-1:0] value,
  input  logic             last,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [1:0]       out_index,
  input  logic [15:0]      activation,
  input  logic [1:0]       best_class,
  input  logic             last_result,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  idx;
    logic [15:0] act;
    logic [1:0]  best;
    logic        fin;
  } neuron_out_t;

  localparam int SIG_POINTS [17] = '{
    32768, 40793, 47910, 53580, 57724, 60565, 62428, 63615, 64357,
    64816, 65097, 65269, 65374, 65437, 65476, 65500, 65514
  };

  neuron_out_t       expected_outs [$];
  logic [VAL_W-1:0]  w_hidden [MAX_INPUTS*MAX_HIDDEN];
  logic [VAL_W-1:0]  w_out [MAX_HIDDEN*NUM_OUTPUTS];
  logic [VAL_W-1:0]  features [MAX_INPUTS];
  logic [15:0]       hidden_acts [MAX_HIDDEN];
  int unsigned       n_inputs;
  int unsigned       n_hidden;

  function automatic logic [15:0] sigmoid_lut(longint z);
    longint m;
    longint g;
    int     seg;
    if (z > 32767) z = 32767;
    if (z < -32768) z = -32768;
    m = (z < 0) ? -z : z;
    seg = int'(m >> 11);
    if (seg >= 16) g = SIG_POINTS[16];
    else g = SIG_POINTS[seg] +
             (((SIG_POINTS[seg+1] - SIG_POINTS[seg]) * (m & 2047)) >> 11);
    if (z < 0) g = 65536 - g;
    return g[15:0];
  endfunction

  task automatic evaluate_network();
    int unsigned ni;
    int unsigned nh;
    longint      acc;
    logic [15:0] acts [NUM_OUTPUTS];
    int          best;
    neuron_out_t r;
    ni = (n_inputs > MAX_INPUTS) ? MAX_INPUTS : n_inputs;
    nh = (n_hidden > MAX_HIDDEN) ? MAX_HIDDEN : n_hidden;
    for (int i = 0; i < nh; i++) begin
      acc = 0;
      for (int j = 0; j < ni; j++)
        acc += longint'($signed(w_hidden[j*MAX_HIDDEN+i])) * longint'($signed(features[j]));
      hidden_acts[i] = sigmoid_lut(acc >>> 12);
    end
    best = 0;
    for (int k = 0; k < NUM_OUTPUTS; k++) begin
      acc = 0;
      for (int i = 0; i < nh; i++)
        acc += longint'($signed(w_out[i*NUM_OUTPUTS+k])) * longint'({1'b0, hidden_acts[i]});
      acts[k] = sigmoid_lut(acc >>> 16);
      if (acts[k] > acts[best]) best = k;
    end
    for (int k = 0; k < NUM_OUTPUTS; k++) begin
      r.idx  = k[1:0];
      r.act  = acts[k];
      r.best = best[1:0];
      r.fin  = (k == NUM_OUTPUTS - 1);
      expected_outs.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    neuron_out_t e;
    if (rst) begin
      n_inputs = 636;
      n_hidden = 120;
      errors   = 0;
      expected_outs.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_INPUTS) n_inputs = cfg_data;
        else n_hidden = cfg_data[7:0];
      end
      if (in_valid && in_ready) begin
        case (req_t'(req_type))
          REQ_HIDDEN_W: w_hidden[src_index*MAX_HIDDEN+dst_neuron] = value;
          REQ_OUTPUT_W: begin
            if (src_index < MAX_HIDDEN && dst_neuron < NUM_OUTPUTS)
              w_out[src_index*NUM_OUTPUTS+dst_neuron] = value;
          end
          REQ_FEATURE: begin
            features[src_index] = value;
            if (last) evaluate_network();
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_outs.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: idx %0d act %0d best %0d last %0b",
                     out_index, activation, best_class, last_result);
        end else begin
          e = expected_outs.pop_front();
          if (e.idx !== out_index || e.act !== activation ||
              e.best !== best_class || e.fin !== last_result) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp idx %0d act %0d best %0d last %0b, got %0d %0d %0d %0b",
                       e.idx, e.act, e.best, e.fin,
                       out_index, activation, best_class, last_result);
          end
        end
      end
    end
    pending = expected_outs.size();
  end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the perceptron unit: fills the weight memories and feature store
// for several small count settings, including zero counts, runs the network,
// queues runs behind one long result stall, then sends random weight,
// feature and noise requests with random idling. The checker compares
// every result.
// ----------------------------------------------------------------------------
module testbench;
  import tlp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [1:0]       req_type;
  logic [SRC_W-1:0] src_index;
  logic [DST_W-1:0] dst_neuron;
  logic [VAL_W-1:0] value;
  logic             last;
  logic             out_valid;
  logic             out_ready;
  logic [1:0]       out_index;
  logic [15:0]      activation;
  logic [1:0]       best_class;
  logic             last_result;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               errors;
  int               pending;
  int               cycles;
  bit               busy_sender;
  bit               hold_go;
  bit               hold_done;

  two_layer_perceptron_sigmoid_unit uut (.*);

  tlp_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_req(req_t t, int src, int dst, logic [15:0] v, bit lst);
    int gap;
    gap = busy_sender ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= t;
    src_index  <= src[SRC_W-1:0];
    dst_neuron <= dst[DST_W-1:0];
    value      <= v;
    last       <= lst;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_counts(int ni, int nh);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INPUTS;
    cfg_data  <= ni[CFG_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_HIDDEN;
    cfg_data  <= nh[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int ni, int nh, int count, bit rare_runs);
    int          r;
    logic [15:0] v;
    bit          lst;
    drain();
    set_counts(ni, nh);
    for (int n = 0; n < count; n++) begin
      r   = $urandom_range(0, 99);
      v   = 16'($urandom());
      lst = rare_runs ? 1'b0 : ($urandom_range(0, 3) == 0);
      if (r < 20) send_req(REQ_HIDDEN_W, $urandom_range(0, 3), $urandom_range(0, 3), v, 0);
      else if (r < 35) send_req(REQ_OUTPUT_W, $urandom_range(0, 3), $urandom_range(0, 2), v, 0);
      else if (r < 60) send_req(REQ_FEATURE, $urandom_range(0, 3), $urandom(), v, lst);
      else if (r < 68) send_req(REQ_NONE, $urandom(), $urandom(), v, 1'($urandom()));
      else if (r < 76) send_req(REQ_OUTPUT_W, $urandom_range(128, 1023), $urandom(), v, 1);
      else if (r < 84) send_req(REQ_OUTPUT_W, $urandom(), $urandom_range(3, 127), v, 0);
      else if (r < 92) send_req(REQ_HIDDEN_W, $urandom(), $urandom(), v, 1);
      else send_req(REQ_FEATURE, $urandom_range(4, 1023), $urandom(), v, 0);
    end
    send_req(REQ_FEATURE, $urandom_range(0, 3), $urandom(), 16'($urandom()), 1);
  endtask

  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_go && !hold_done) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_done = 1;
      end else begin
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    req_type   = REQ_NONE;
    src_index  = '0;
    dst_neuron = '0;
    value      = '0;
    last       = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_INPUTS;
    cfg_data   = '0;
    busy_sender = 0;
    hold_go    = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one feature, four hidden neurons, back to back
    set_counts(1, 4);
    busy_sender = 1;
    for (int i = 0; i < 4; i++)
      send_req(REQ_HIDDEN_W, 0, i, 16'($urandom()), 0);
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < NUM_OUTPUTS; k++)
        send_req(REQ_OUTPUT_W, i, k, 16'($urandom()), 0);
    send_req(REQ_FEATURE, 0, 0, 16'h7fff, 1);
    busy_sender = 0;

    // saturating sums at both extremes, ties
    drain();
    set_counts(4, 4);
    for (int j = 0; j < 4; j++)
      for (int i = 0; i < 4; i++)
        send_req(REQ_HIDDEN_W, j, i, (i[0]) ? 16'h8000 : 16'h7fff, 0);
    for (int j = 0; j < 4; j++) send_req(REQ_FEATURE, j, 0, 16'h7fff, j == 3);
    for (int j = 0; j < 4; j++) send_req(REQ_FEATURE, j, 0, 16'h8000, j == 3);
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < NUM_OUTPUTS; k++) send_req(REQ_OUTPUT_W, i, k, 16'h0000, 0);
    send_req(REQ_FEATURE, 0, 0, 16'h1234, 1);

    // queue runs behind a long result stall
    drain();
    hold_go = 1;
    for (int n = 0; n < 3; n++)
      send_req(REQ_FEATURE, n, 0, 16'($urandom()), 1);

    random_phase(4, 4, 16, 0);
    random_phase(0, 3, 4, 0);
    random_phase(4, 0, 4, 0);
    random_phase(3, 4, 8, 0);
    random_phase(1, 4, 4, 0);
    random_phase(2, 2, 8, 0);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0 || !hold_done);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
